>>> rtl/deca_pkg.sv
// shared types and constants for the dual event coincidence alert
// no dependencies; used by deca_regs, deca_core and the top level
`default_nettype none

package deca_pkg;

	// item command codes
	localparam logic [1:0] CMD_AUDIO  = 2'd0;
	localparam logic [1:0] CMD_VISION = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	// register file layout
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_AUDIO_LABEL  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_VISION_LABEL = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_AUDIO_CONF   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_VISION_CONF  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FUSION_WIN   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_COOLDOWN     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LED_HOLD     = 3'd6;

	// register reset values
	localparam logic [7:0]  RST_AUDIO_LABEL  = 8'd2;
	localparam logic [7:0]  RST_VISION_LABEL = 8'd1;
	localparam logic [6:0]  RST_MIN_CONF     = 7'd70;
	localparam logic [31:0] RST_FUSION_WIN   = 32'd3000;
	localparam logic [31:0] RST_COOLDOWN     = 32'd30000;
	localparam logic [31:0] RST_LED_HOLD     = 32'd2000;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  event_label;
		logic [6:0]  event_confidence;
		logic [31:0] event_time_ms;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic        alert;
		logic        led_on;
		logic [7:0]  alert_audio_label;
		logic [6:0]  alert_audio_confidence;
		logic [7:0]  alert_vision_label;
		logic [6:0]  alert_vision_confidence;
		logic [31:0] alert_audio_time;
		logic [31:0] alert_vision_time;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  audio_target_label;
		logic [7:0]  vision_target_label;
		logic [6:0]  audio_min_confidence;
		logic [6:0]  vision_min_confidence;
		logic [31:0] fusion_window_ms;
		logic [31:0] cooldown_ms;
		logic [31:0] led_hold_ms;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/deca_regs.sv
// configuration register file behind the bus port
// depends on deca_pkg
`default_nettype none

module deca_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [deca_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output deca_pkg::cfg_t                    cfg
);
	import deca_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.audio_target_label    <= RST_AUDIO_LABEL;
			cfg_q.vision_target_label   <= RST_VISION_LABEL;
			cfg_q.audio_min_confidence  <= RST_MIN_CONF;
			cfg_q.vision_min_confidence <= RST_MIN_CONF;
			cfg_q.fusion_window_ms      <= RST_FUSION_WIN;
			cfg_q.cooldown_ms           <= RST_COOLDOWN;
			cfg_q.led_hold_ms           <= RST_LED_HOLD;
		end else if (wr_en) begin
			unique case (idx)
				REG_AUDIO_LABEL:  cfg_q.audio_target_label    <= pwdata[7:0];
				REG_VISION_LABEL: cfg_q.vision_target_label   <= pwdata[7:0];
				REG_AUDIO_CONF:   cfg_q.audio_min_confidence  <= pwdata[6:0];
				REG_VISION_CONF:  cfg_q.vision_min_confidence <= pwdata[6:0];
				REG_FUSION_WIN:   cfg_q.fusion_window_ms      <= pwdata;
				REG_COOLDOWN:     cfg_q.cooldown_ms           <= pwdata;
				REG_LED_HOLD:     cfg_q.led_hold_ms           <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_AUDIO_LABEL:  prdata = {24'd0, cfg_q.audio_target_label};
			REG_VISION_LABEL: prdata = {24'd0, cfg_q.vision_target_label};
			REG_AUDIO_CONF:   prdata = {25'd0, cfg_q.audio_min_confidence};
			REG_VISION_CONF:  prdata = {25'd0, cfg_q.vision_min_confidence};
			REG_FUSION_WIN:   prdata = cfg_q.fusion_window_ms;
			REG_COOLDOWN:     prdata = cfg_q.cooldown_ms;
			REG_LED_HOLD:     prdata = cfg_q.led_hold_ms;
			default:          prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/deca_core.sv
// kept events, alert decision and led timer for one item per cycle while step is high
// depends on deca_pkg
`default_nettype none

module deca_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire deca_pkg::in_item_t item,
	input  wire deca_pkg::cfg_t     cfg,
	output deca_pkg::out_item_t     res
);
	import deca_pkg::*;

	logic [7:0]  a_lab_q, v_lab_q;
	logic [6:0]  a_conf_q, v_conf_q;
	logic [31:0] a_time_q, v_time_q;
	logic [31:0] last_alert_q;
	logic        led_q;

	logic [7:0]  a_lab, v_lab;
	logic [6:0]  a_conf, v_conf;
	logic [31:0] a_time, v_time;
	logic        is_event;
	logic [31:0] time_gap;
	logic [31:0] since_last;
	logic        alert;
	logic [31:0] last_alert_nxt;
	logic [31:0] since_nxt;
	logic        led_nxt;

	always_comb begin
		a_lab    = a_lab_q;
		a_conf   = a_conf_q;
		a_time   = a_time_q;
		v_lab    = v_lab_q;
		v_conf   = v_conf_q;
		v_time   = v_time_q;
		is_event = 1'b0;
		unique case (item.command)
			CMD_AUDIO: begin
				a_lab    = item.event_label;
				a_conf   = item.event_confidence;
				a_time   = item.event_time_ms;
				is_event = 1'b1;
			end
			CMD_VISION: begin
				v_lab    = item.event_label;
				v_conf   = item.event_confidence;
				v_time   = item.event_time_ms;
				is_event = 1'b1;
			end
			default: ;
		endcase

		time_gap   = (a_time > v_time) ? a_time - v_time : v_time - a_time;
		since_last = item.now_ms - last_alert_q;

		alert = is_event
			&& (a_time != 32'd0) && (v_time != 32'd0)
			&& (a_lab == cfg.audio_target_label) && (a_conf >= cfg.audio_min_confidence)
			&& (v_lab == cfg.vision_target_label) && (v_conf >= cfg.vision_min_confidence)
			&& (time_gap <= cfg.fusion_window_ms)
			&& (since_last >= cfg.cooldown_ms);

		// after an alert the elapsed time is zero, which never exceeds the hold
		last_alert_nxt = alert ? item.now_ms : last_alert_q;
		since_nxt      = alert ? 32'd0 : since_last;
		led_nxt        = (alert || led_q) && !(since_nxt > cfg.led_hold_ms);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_lab_q      <= '0;
			a_conf_q     <= '0;
			a_time_q     <= '0;
			v_lab_q      <= '0;
			v_conf_q     <= '0;
			v_time_q     <= '0;
			last_alert_q <= '0;
			led_q        <= 1'b0;
		end else if (step) begin
			a_lab_q      <= a_lab;
			a_conf_q     <= a_conf;
			a_time_q     <= a_time;
			v_lab_q      <= v_lab;
			v_conf_q     <= v_conf;
			v_time_q     <= v_time;
			last_alert_q <= last_alert_nxt;
			led_q        <= led_nxt;
		end
	end

	assign res.alert                   = alert;
	assign res.led_on                  = led_nxt;
	assign res.alert_audio_label       = a_lab;
	assign res.alert_audio_confidence  = a_conf;
	assign res.alert_vision_label      = v_lab;
	assign res.alert_vision_confidence = v_conf;
	assign res.alert_audio_time        = a_time;
	assign res.alert_vision_time       = v_time;

endmodule

`default_nettype wire

>>> rtl/dual_event_coincidence_alert.sv
// dual event coincidence alert: each item passes the input register, then the result register
// throughput one item per cycle while res_stall is low; the input register and result register decouple the sides
// the result register holds while res_stall is high; the input register takes one more item
// reset (arst_n low, asynchronous): kept events, last alert time and led cleared to zero,
// registers to their defaults, both pipeline valids cleared
// depends on deca_pkg, deca_regs, deca_core
`default_nettype none

module dual_event_coincidence_alert (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// event channel
	input  wire logic                         evt_valid,
	output logic                              evt_stall,
	input  wire deca_pkg::in_item_t           evt,
	// result channel
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output deca_pkg::out_item_t               res,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [deca_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import deca_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;
	out_item_t res_nxt;
	logic      advance;
	logic      step;

	// register file
	deca_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// result register can take a new result when empty or when its transfer completes
	assign advance = !valid_s2 || !res_stall;
	// the item in the input register is processed (and the state updated) as it moves on
	assign step = valid_s1 && advance;
	// input register is free when empty or when it moves on this cycle
	assign evt_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!evt_stall) begin
				valid_s1 <= evt_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers carry no reset
	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			item_s1 <= evt;
		end
		if (step) begin
			res_s2 <= res_nxt;
		end
	end

	// event store, coincidence check, cooldown and led timer
	deca_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_nxt)
	);

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

>>> test/deca_alert_checker.sv
`timescale 1ns / 1ps
// checker for dual_event_coincidence_alert: mirrors the settings, kept events,
// cooldown and led from the transfers it sees and compares every result
// depends on deca_pkg
module deca_alert_checker
	import deca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	input  logic              evt_stall,
	input  in_item_t          evt,
	input  logic              res_valid,
	input  logic              res_stall,
	input  out_item_t         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output int unsigned       fail_count,
	output int unsigned       due_count
);

	cfg_t        settings;
	logic [7:0]  aud_label, vis_label;
	logic [6:0]  aud_conf, vis_conf;
	logic [31:0] aud_time, vis_time, last_alert_ms;
	logic        led;
	out_item_t   alerts_due[$];

	initial fail_count = 0;

	// one item: store the event, try the coincidence, then the led turn-off
	task automatic fuse_step(input in_item_t item, output out_item_t outcome);
		logic [31:0] spread;
		logic [31:0] since_alert;
		logic        fired;
		fired = 1'b0;
		case (item.command)
			CMD_AUDIO: begin
				aud_label = item.event_label;
				aud_conf  = item.event_confidence;
				aud_time  = item.event_time_ms;
			end
			CMD_VISION: begin
				vis_label = item.event_label;
				vis_conf  = item.event_confidence;
				vis_time  = item.event_time_ms;
			end
			default: ;
		endcase
		if (item.command == CMD_AUDIO || item.command == CMD_VISION) begin
			spread = (aud_time > vis_time) ? aud_time - vis_time : vis_time - aud_time;
			since_alert = item.now_ms - last_alert_ms;
			if (aud_time != 0 && vis_time != 0
					&& aud_label == settings.audio_target_label
					&& aud_conf >= settings.audio_min_confidence
					&& vis_label == settings.vision_target_label
					&& vis_conf >= settings.vision_min_confidence
					&& spread <= settings.fusion_window_ms
					&& since_alert >= settings.cooldown_ms) begin
				fired = 1'b1;
				last_alert_ms = item.now_ms;
				led = 1'b1;
			end
		end
		since_alert = item.now_ms - last_alert_ms;
		if (led && since_alert > settings.led_hold_ms)
			led = 1'b0;
		outcome.alert                   = fired;
		outcome.led_on                  = led;
		outcome.alert_audio_label       = aud_label;
		outcome.alert_audio_confidence  = aud_conf;
		outcome.alert_vision_label      = vis_label;
		outcome.alert_vision_confidence = vis_conf;
		outcome.alert_audio_time        = aud_time;
		outcome.alert_vision_time       = vis_time;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t predicted;
		out_item_t wanted;
		if (!arst_n) begin
			settings.audio_target_label    = RST_AUDIO_LABEL;
			settings.vision_target_label   = RST_VISION_LABEL;
			settings.audio_min_confidence  = RST_MIN_CONF;
			settings.vision_min_confidence = RST_MIN_CONF;
			settings.fusion_window_ms      = RST_FUSION_WIN;
			settings.cooldown_ms           = RST_COOLDOWN;
			settings.led_hold_ms           = RST_LED_HOLD;
			aud_label = '0; aud_conf = '0; aud_time = '0;
			vis_label = '0; vis_conf = '0; vis_time = '0;
			last_alert_ms = '0;
			led = 1'b0;
			alerts_due.delete();
			due_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_AUDIO_LABEL:  settings.audio_target_label    = pwdata[7:0];
					REG_VISION_LABEL: settings.vision_target_label   = pwdata[7:0];
					REG_AUDIO_CONF:   settings.audio_min_confidence  = pwdata[6:0];
					REG_VISION_CONF:  settings.vision_min_confidence = pwdata[6:0];
					REG_FUSION_WIN:   settings.fusion_window_ms      = pwdata;
					REG_COOLDOWN:     settings.cooldown_ms           = pwdata;
					REG_LED_HOLD:     settings.led_hold_ms           = pwdata;
					default: ;
				endcase
			end
			if (evt_valid && !evt_stall) begin
				fuse_step(evt, predicted);
				alerts_due.push_back(predicted);
			end
			if (res_valid && !res_stall) begin
				if (alerts_due.size() == 0) begin
					fail_count++;
					$display("%0t: result with no item outstanding, expected none, actual %h",
						$time, res);
				end else begin
					wanted = alerts_due.pop_front();
					check_field("alert", 32'(wanted.alert), 32'(res.alert));
					check_field("led_on", 32'(wanted.led_on), 32'(res.led_on));
					check_field("alert_audio_label", 32'(wanted.alert_audio_label),
						32'(res.alert_audio_label));
					check_field("alert_audio_confidence",
						32'(wanted.alert_audio_confidence),
						32'(res.alert_audio_confidence));
					check_field("alert_vision_label", 32'(wanted.alert_vision_label),
						32'(res.alert_vision_label));
					check_field("alert_vision_confidence",
						32'(wanted.alert_vision_confidence),
						32'(res.alert_vision_confidence));
					check_field("alert_audio_time", wanted.alert_audio_time,
						res.alert_audio_time);
					check_field("alert_vision_time", wanted.alert_vision_time,
						res.alert_vision_time);
				end
			end
			due_count = alerts_due.size();
		end
	end

endmodule

>>> test/dual_event_coincidence_alert_tb.sv
`timescale 1ns / 1ps
// top of the testbench for dual_event_coincidence_alert: clock, reset, stimulus,
// register writes and the verdict; depends on deca_pkg, the block and deca_alert_checker
module dual_event_coincidence_alert_tb;
	import deca_pkg::*;

	localparam int unsigned QUIET_LIMIT     = 5000;
	localparam int unsigned RANDOM_PHASES   = 6;
	localparam int unsigned ITEMS_PER_PHASE = 122;
	localparam int unsigned HOLD_OFF_CYCLES = 64;
	localparam int unsigned SETTLE_CYCLES   = 6;
	// index past the last register, writes there must be ignored
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              evt_valid = 1'b0;
	logic              evt_stall;
	in_item_t          evt       = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	out_item_t         res;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [31:0]       pwdata    = '0;
	logic [31:0]       prdata;
	logic              pready;

	int unsigned fail_count;
	int unsigned due_count;
	// idle rates in percent, changed between phases by the stimulus
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	// long receiver hold-off, requested by the stimulus and served by the receiver
	logic        hold_off_req  = 1'b0;
	logic        hold_off_done = 1'b0;
	// current settings, only used to shape events that can raise alerts
	cfg_t        cfg_shadow;
	// running wall clock and a shared timestamp so audio and vision can coincide
	logic [31:0] clock_ms  = '0;
	logic [31:0] pair_time = 32'd1;
	int unsigned quiet_cycles = 0;

	always #4 clk = ~clk;

	dual_event_coincidence_alert DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	deca_alert_checker CHK (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.evt        (evt),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	// watchdog: ends the run after too many cycles without any transfer
	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stall at the current rate, plus one long hold-off
	// while the sender keeps offering, so the block fills and stalls its input
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				res_stall = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_done = 1'b1;
			end
			res_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	// one event transfer: optional idle gap, then hold the payload until taken
	// called and returns at a falling edge; valid stays high between back-to-back items
	task automatic send_item(input in_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			evt_valid = 1'b0;
			@(negedge clk);
		end
		evt       = item;
		evt_valid = 1'b1;
		@(posedge clk);
		while (evt_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [1:0] command, input logic [7:0] label,
			input logic [6:0] conf, input logic [31:0] event_ms, input logic [31:0] now);
		in_item_t item;
		item.command          = command;
		item.event_label      = label;
		item.event_confidence = conf;
		item.event_time_ms    = event_ms;
		item.now_ms           = now;
		send_item(item);
	endtask

	// register write: setup cycle, then access cycle, taken at the rising edge of the access cycle
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic load_settings(input cfg_t c);
		write_reg(REG_AUDIO_LABEL,  {24'd0, c.audio_target_label});
		write_reg(REG_VISION_LABEL, {24'd0, c.vision_target_label});
		write_reg(REG_AUDIO_CONF,   {25'd0, c.audio_min_confidence});
		write_reg(REG_VISION_CONF,  {25'd0, c.vision_min_confidence});
		write_reg(REG_FUSION_WIN,   c.fusion_window_ms);
		write_reg(REG_COOLDOWN,     c.cooldown_ms);
		write_reg(REG_LED_HOLD,     c.led_hold_ms);
		cfg_shadow = c;
	endtask

	// wait until every result is back, then let the pipeline settle
	task automatic drain();
		evt_valid = 1'b0;
		while (due_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly events that match the targets and sit close in time, so alerts,
	// cooldowns and led timeouts all happen; the rest are ticks and raw noise
	task automatic make_random_item(output in_item_t item);
		int unsigned pick;
		logic [6:0]  floor_conf;
		logic        is_audio;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 3)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(400);
		item.command          = CMD_TICK;
		item.event_label      = 8'($urandom);
		item.event_confidence = 7'($urandom);
		item.event_time_ms    = $urandom;
		item.now_ms           = clock_ms;
		if (pick < 70) begin
			is_audio     = (pick < 35);
			item.command = is_audio ? CMD_AUDIO : CMD_VISION;
			floor_conf   = is_audio ? cfg_shadow.audio_min_confidence
					: cfg_shadow.vision_min_confidence;
			if ($urandom_range(9) != 0)
				item.event_label = is_audio ? cfg_shadow.audio_target_label
						: cfg_shadow.vision_target_label;
			if ($urandom_range(9) != 0)
				item.event_confidence = 7'($urandom_range(100, floor_conf));
			// keep a few fully random timestamps, pair about a quarter of the others, set the rest just before now
			if ($urandom_range(19) != 0) begin
				if ($urandom_range(3) == 0)
					item.event_time_ms = pair_time;
				else
					item.event_time_ms = clock_ms - $urandom_range(600);
			end
			if (is_audio)
				pair_time = item.event_time_ms;
		end else if (pick >= 85) begin
			// noise, all four command codes including the unused one
			item.command = 2'($urandom);
		end
	endtask

	initial begin : stimulus
		in_item_t item;
		cfg_t     c;

		cfg_shadow.audio_target_label    = RST_AUDIO_LABEL;
		cfg_shadow.vision_target_label   = RST_VISION_LABEL;
		cfg_shadow.audio_min_confidence  = RST_MIN_CONF;
		cfg_shadow.vision_min_confidence = RST_MIN_CONF;
		cfg_shadow.fusion_window_ms      = RST_FUSION_WIN;
		cfg_shadow.cooldown_ms           = RST_COOLDOWN;
		cfg_shadow.led_hold_ms           = RST_LED_HOLD;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part on the reset settings
		// tick right after reset
		send_fields(CMD_TICK, 8'd0, 7'd0, 32'd0, 32'd0);
		// audio alone, no vision event yet
		send_fields(CMD_AUDIO, 8'd2, 7'd70, 32'd1000, 32'd1000);
		// a full match, but still inside the first cooldown after reset
		send_fields(CMD_VISION, 8'd1, 7'd70, 32'd1500, 32'd1500);
		send_fields(CMD_TICK, 8'hff, 7'h7f, 32'hffff_ffff, 32'd40000);
		// events too far apart
		send_fields(CMD_AUDIO, 8'd2, 7'd100, 32'd40000, 32'd40000);
		// alert, confidence above one hundred
		send_fields(CMD_VISION, 8'd1, 7'd127, 32'd41000, 32'd41000);
		// led holds at exactly the hold time, then goes off one past it
		send_fields(CMD_TICK, 8'd0, 7'd0, 32'd0, 32'd43000);
		send_fields(CMD_TICK, 8'd0, 7'd0, 32'd0, 32'd43001);
		// confidence one short, then a wrong label
		send_fields(CMD_AUDIO, 8'd2, 7'd69, 32'd43000, 32'd43000);
		send_fields(CMD_AUDIO, 8'd3, 7'd100, 32'd43000, 32'd43000);
		// unused command acts as a tick
		send_fields(2'd3, 8'd2, 7'd100, 32'd5, 32'd80000);
		// timestamp zero means no audio event
		send_fields(CMD_AUDIO, 8'd2, 7'd100, 32'd0, 32'd80000);
		send_fields(CMD_VISION, 8'd1, 7'd100, 32'd80000, 32'd80000);
		// top of the time range, window distance exactly minus one
		send_fields(CMD_AUDIO, 8'd2, 7'd100, 32'hffff_ffff, 32'hffff_ffff);
		send_fields(CMD_VISION, 8'd1, 7'd70, 32'hffff_f448, 32'hffff_ffff);
		// led hold measured across the wrap of now
		send_fields(CMD_TICK, 8'd0, 7'd0, 32'd0, 32'd1999);
		send_fields(CMD_TICK, 8'd0, 7'd0, 32'd0, 32'd2000);
		// distance exactly the window; cooldown not yet met, then exactly met
		send_fields(CMD_VISION, 8'd1, 7'd100, 32'hffff_f447, 32'd20000);
		send_fields(CMD_VISION, 8'd1, 7'd100, 32'hffff_f447, 32'd29999);
		// all zero and all one fields
		send_fields(CMD_VISION, 8'd0, 7'd0, 32'd1, 32'd0);
		send_fields(CMD_AUDIO, 8'hff, 7'h7f, 32'hffff_ffff, 32'hffff_ffff);
		send_fields(CMD_TICK, 8'hff, 7'h7f, 32'hffff_ffff, 32'hffff_ffff);

		// random phases, each on its own settings, written while idle
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			case (ph)
				0: c = '{8'd2, 8'd1, 7'd50, 7'd60, 32'd500, 32'd200, 32'd100};
				1: begin
					// write past the register file first, it must change nothing
					write_reg(REG_UNUSED, 32'hffff_ffff);
					c = '{8'd0, 8'd0, 7'd0, 7'd0, 32'd0, 32'd0, 32'd0};
				end
				2: c = '{8'hff, 8'hff, 7'd100, 7'd127, 32'hffff_ffff, 32'hffff_ffff,
					32'hffff_ffff};
				4: c = '{8'd7, 8'd9, 7'd90, 7'd80, 32'd50, 32'd1000, 32'd3000};
				default: begin
					c.audio_target_label    = 8'($urandom_range(3));
					c.vision_target_label   = 8'($urandom_range(3));
					c.audio_min_confidence  = 7'($urandom_range(100));
					c.vision_min_confidence = 7'($urandom_range(100));
					c.fusion_window_ms      = $urandom_range(2000);
					c.cooldown_ms           = $urandom_range(1000);
					c.led_hold_ms           = $urandom_range(500);
				end
			endcase
			load_settings(c);
			// receiver mostly idle first, then the sender, then neither
			case (ph / 2)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (ph == 4)
				hold_off_req = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				make_random_item(item);
				send_item(item);
			end
		end

		drain();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
rtl/deca_pkg.sv
rtl/deca_regs.sv
rtl/deca_core.sv
rtl/dual_event_coincidence_alert.sv
test/deca_alert_checker.sv
test/dual_event_coincidence_alert_tb.sv
